>>> hdl/lavm_pkg.sv
package lavm_pkg;

  localparam int NSqrt = 8;
  localparam int NDiv = 8;
  localparam int NItem = 22;
  localparam int NStage = 23;

  typedef struct packed {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               degen;
  } item_t;

  typedef struct packed {
    logic [31:0] n;
    logic [31:0] r;
  } sq_t;

  typedef struct packed {
    logic [15:0] len;
    logic [15:0] rem;
    logic [31:0] num;
    logic [31:0] q;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t a, input int k);
    logic [32:0] bitv;
    logic [32:0] sum;
    sq_t         o;
    bitv = 33'(1) << (2 * k);
    sum = {1'b0, a.r} + bitv;
    if ({1'b0, a.n} >= sum) begin
      o.n = 32'({1'b0, a.n} - sum);
      o.r = 32'({2'b0, a.r[31:1]} + bitv);
    end else begin
      o.n = a.n;
      o.r = {1'b0, a.r[31:1]};
    end
    return o;
  endfunction

  function automatic dv_t div_step4(input dv_t a);
    dv_t         o;
    logic [16:0] rem2;
    o = a;
    for (int i = 0; i < 4; i++) begin
      rem2 = {o.rem, o.num[31]};
      o.num = {o.num[30:0], 1'b0};
      if (rem2 >= {1'b0, o.len}) begin
        o.rem = 16'(rem2 - {1'b0, o.len});
        o.q = {o.q[30:0], 1'b1};
      end else begin
        o.rem = rem2[15:0];
        o.q = {o.q[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic signed [63:0] rnd_q14(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m = (mag + 64'd8192) >> 14;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat_q14(input logic signed [63:0] v);
    if (v < -64'sd16384) return -16'sd16384;
    else if (v > 64'sd16384) return 16'sd16384;
    else return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat_q16(input logic signed [63:0] v);
    if (v < -64'sd2147483648) return 32'h8000_0000;
    else if (v > 64'sd2147483647) return 32'h7fff_ffff;
    else return v[31:0];
  endfunction

endpackage

>>> hdl/look_at_view_matrix.sv
// Look-at view matrix against world up (0,1,0). One camera pose is taken every
// cycle while the output is not stalled; most of the depth is the 16-stage
// square root and reciprocal that normalize the right vector. The whole
// pipeline holds while a finished beat waits at the output.
module look_at_view_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] front_x_i,
  input  logic signed [15:0] front_y_i,
  input  logic signed [15:0] front_z_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [15:0] back_x_o,
  output logic signed [15:0] back_y_o,
  output logic signed [15:0] back_z_o,
  output logic signed [31:0] trans_x_o,
  output logic signed [31:0] trans_y_o,
  output logic signed [31:0] trans_z_o,
  output logic               degenerate_o
);

  logic                  adv;
  logic [lavm_pkg::NStage-1:0] vld_q;
  lavm_pkg::item_t       item_q [lavm_pkg::NItem];
  lavm_pkg::item_t       item_in;
  logic [31:0]           s_q;
  logic [28:0]           inv;

  logic signed [32:0] xl_q, zl_q;
  logic signed [29:0] xh_q, zh_q;
  logic signed [15:0] rx_q [5];
  logic signed [15:0] rz_q [5];
  logic signed [31:0] rzfy_q, rzfx_q, rxfz_q, rxfy_q;
  logic signed [15:0] ux_q [3];
  logic signed [15:0] uy_q [3];
  logic signed [15:0] uz_q [3];
  logic signed [15:0] bx_q [3];
  logic signed [15:0] by_q [3];
  logic signed [15:0] bz_q [3];
  logic signed [47:0] prx_q, prz_q, pux_q, puy_q, puz_q, pbx_q, pby_q, pbz_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  logic               dg_q;
  logic signed [63:0] vx, vz;

  assign adv = !vld_q[lavm_pkg::NStage-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    item_in.fx = front_x_i;
    item_in.fy = front_y_i;
    item_in.fz = front_z_i;
    item_in.px = pos_x_i;
    item_in.py = pos_y_i;
    item_in.pz = pos_z_i;
    item_in.degen = (front_x_i == 16'sd0) && (front_z_i == 16'sd0);
    vx = (64'(xh_q) <<< 16) + 64'(xl_q);
    vz = (64'(zh_q) <<< 16) + 64'(zl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[lavm_pkg::NStage-2:0], in_valid_i};
    end
  end

  lavm_norm u_norm (
    .clk_i (clk_i),
    .en_i  (adv),
    .s_i   (s_q),
    .inv_o (inv)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[0] <= item_in;
      s_q <= 32'(32'(front_x_i) * 32'(front_x_i)) + 32'(32'(front_z_i) * 32'(front_z_i));
      for (int j = 1; j < lavm_pkg::NItem; j++) begin
        item_q[j] <= item_q[j-1];
      end

      // right vector, reciprocal split into two partial products
      xl_q <= 33'(item_q[16].fx) * 33'($signed({1'b0, inv[15:0]}));
      zl_q <= 33'(item_q[16].fz) * 33'($signed({1'b0, inv[15:0]}));
      xh_q <= 30'(item_q[16].fx) * 30'($signed({1'b0, inv[28:16]}));
      zh_q <= 30'(item_q[16].fz) * 30'($signed({1'b0, inv[28:16]}));

      if (item_q[17].degen) begin
        rx_q[0] <= '0;
        rz_q[0] <= '0;
      end else begin
        rx_q[0] <= lavm_pkg::sat_q14(-lavm_pkg::rnd_q14(vz));
        rz_q[0] <= lavm_pkg::sat_q14(lavm_pkg::rnd_q14(vx));
      end
      for (int j = 1; j < 5; j++) begin
        rx_q[j] <= rx_q[j-1];
        rz_q[j] <= rz_q[j-1];
      end

      // up and back vectors
      rzfy_q <= 32'(rz_q[0]) * 32'(item_q[18].fy);
      rzfx_q <= 32'(rz_q[0]) * 32'(item_q[18].fx);
      rxfz_q <= 32'(rx_q[0]) * 32'(item_q[18].fz);
      rxfy_q <= 32'(rx_q[0]) * 32'(item_q[18].fy);

      ux_q[0] <= lavm_pkg::sat_q14(-lavm_pkg::rnd_q14(64'(rzfy_q)));
      uy_q[0] <= lavm_pkg::sat_q14(lavm_pkg::rnd_q14(64'(rzfx_q) - 64'(rxfz_q)));
      uz_q[0] <= lavm_pkg::sat_q14(lavm_pkg::rnd_q14(64'(rxfy_q)));
      bx_q[0] <= lavm_pkg::sat_q14(-64'(item_q[19].fx));
      by_q[0] <= lavm_pkg::sat_q14(-64'(item_q[19].fy));
      bz_q[0] <= lavm_pkg::sat_q14(-64'(item_q[19].fz));
      for (int j = 1; j < 3; j++) begin
        ux_q[j] <= ux_q[j-1];
        uy_q[j] <= uy_q[j-1];
        uz_q[j] <= uz_q[j-1];
        bx_q[j] <= bx_q[j-1];
        by_q[j] <= by_q[j-1];
        bz_q[j] <= bz_q[j-1];
      end

      // translation products
      prx_q <= 48'(rx_q[2]) * 48'(item_q[20].px);
      prz_q <= 48'(rz_q[2]) * 48'(item_q[20].pz);
      pux_q <= 48'(ux_q[0]) * 48'(item_q[20].px);
      puy_q <= 48'(uy_q[0]) * 48'(item_q[20].py);
      puz_q <= 48'(uz_q[0]) * 48'(item_q[20].pz);
      pbx_q <= 48'(bx_q[0]) * 48'(item_q[20].px);
      pby_q <= 48'(by_q[0]) * 48'(item_q[20].py);
      pbz_q <= 48'(bz_q[0]) * 48'(item_q[20].pz);

      tx_q <= lavm_pkg::sat_q16(-lavm_pkg::rnd_q14(64'(prx_q) + 64'(prz_q)));
      ty_q <= lavm_pkg::sat_q16(-lavm_pkg::rnd_q14(64'(pux_q) + 64'(puy_q) + 64'(puz_q)));
      tz_q <= lavm_pkg::sat_q16(-lavm_pkg::rnd_q14(64'(pbx_q) + 64'(pby_q) + 64'(pbz_q)));
      dg_q <= item_q[21].degen;
    end
  end

  assign out_valid_o  = vld_q[lavm_pkg::NStage-1];
  assign right_x_o    = rx_q[4];
  assign right_z_o    = rz_q[4];
  assign up_x_o       = ux_q[2];
  assign up_y_o       = uy_q[2];
  assign up_z_o       = uz_q[2];
  assign back_x_o     = bx_q[2];
  assign back_y_o     = by_q[2];
  assign back_z_o     = bz_q[2];
  assign trans_x_o    = tx_q;
  assign trans_y_o    = ty_q;
  assign trans_z_o    = tz_q;
  assign degenerate_o = dg_q;

endmodule

>>> hdl/lavm_norm.sv
module lavm_norm (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] s_i,
  output logic [28:0] inv_o
);

  lavm_pkg::sq_t sq_q [lavm_pkg::NSqrt];
  lavm_pkg::dv_t dv_q [lavm_pkg::NDiv];
  lavm_pkg::sq_t sq_in;
  lavm_pkg::dv_t dv_in;

  always_comb begin
    sq_in.n = s_i;
    sq_in.r = '0;
    dv_in.len = sq_q[lavm_pkg::NSqrt-1].r[15:0];
    dv_in.rem = '0;
    dv_in.num = 32'h1000_0000 + {17'd0, sq_q[lavm_pkg::NSqrt-1].r[15:1]};
    dv_in.q = '0;
  end

  // square root two bits per stage, then reciprocal four bits per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0] <= lavm_pkg::sqrt_step(lavm_pkg::sqrt_step(sq_in, 15), 14);
      for (int j = 1; j < lavm_pkg::NSqrt; j++) begin
        sq_q[j] <= lavm_pkg::sqrt_step(lavm_pkg::sqrt_step(sq_q[j-1], 15 - 2*j), 14 - 2*j);
      end
      dv_q[0] <= lavm_pkg::div_step4(dv_in);
      for (int j = 1; j < lavm_pkg::NDiv; j++) begin
        dv_q[j] <= lavm_pkg::div_step4(dv_q[j-1]);
      end
    end
  end

  assign inv_o = dv_q[lavm_pkg::NDiv-1].q[28:0];

endmodule
